/* rtl/mqtt_publish_stream_parser_macros.svh */
// ----------------------------------------------------------------------------
// mqtt publish stream parser assertion macros
// shared check wrappers, clocked on i_clk and disabled while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef MQTT_PUBLISH_STREAM_PARSER_MACROS_SVH
`define MQTT_PUBLISH_STREAM_PARSER_MACROS_SVH

// condition that holds at every clock edge out of reset
`define MPSP_CHECK(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// same-cycle implication
`define MPSP_CHECK_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MPSP_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/mpsp_pkg.sv */
// ----------------------------------------------------------------------------
// mpsp_pkg
// types, constants and helpers of the mqtt publish stream parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mpsp_pkg;

    localparam int MAX_LENGTH_BYTES = 4;
    localparam int LEN_W            = 28;
    localparam int TOPIC_W          = 16;
    localparam int BYTE_W           = 8;
    localparam int KIND_W           = 3;
    localparam int RQ_DEPTH         = 4;
    localparam int RQ_PTR_W         = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_W         = $clog2(RQ_DEPTH + 1);

    localparam logic [3:0] PUBLISH_TYPE = 4'h3;

    typedef enum logic [2:0] {
        PH_HEADER   = 3'd0,
        PH_LENGTH   = 3'd1,
        PH_TOPIC_HI = 3'd2,
        PH_TOPIC_LO = 3'd3,
        PH_TOPIC    = 3'd4,
        PH_PAYLOAD  = 3'd5,
        PH_SKIP     = 3'd6
    } t_phase;

    typedef enum logic [KIND_W-1:0] {
        K_TOPIC   = 3'd0,
        K_PAYLOAD = 3'd1,
        K_DONE    = 3'd2,
        K_SKIPPED = 3'd3,
        K_ERROR   = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind                kind;
        logic [BYTE_W-1:0]    out_byte;
        logic [BYTE_W-1:0]    header_byte;
        logic [TOPIC_W-1:0]   topic_length;
        logic [LEN_W-1:0]     payload_length;
        logic [LEN_W-1:0]     packet_length;
        logic                 last;
    } t_result;

    function automatic t_result mk_result(
        input t_kind              kind,
        input logic [BYTE_W-1:0]  data,
        input logic [BYTE_W-1:0]  header,
        input logic [TOPIC_W-1:0] tsize,
        input logic [LEN_W-1:0]   acc,
        input logic               last
    );
        t_result r;
        logic    lengths;
        lengths          = (kind == K_TOPIC) || (kind == K_PAYLOAD) || (kind == K_DONE);
        r.kind           = kind;
        r.out_byte       = ((kind == K_TOPIC) || (kind == K_PAYLOAD)) ? data : '0;
        r.header_byte    = header;
        r.topic_length   = lengths ? tsize : '0;
        r.payload_length = lengths ? (acc - LEN_W'(2) - LEN_W'(tsize)) : '0;
        r.packet_length  = acc;
        r.last           = last;
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/mpsp_if.sv */
// ----------------------------------------------------------------------------
// mpsp stream interfaces
// valid/ready channels for input bytes and parser results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mpsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       restart;

    modport source (output valid, output data_byte, output restart, input ready);
    modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

interface mpsp_out_if import mpsp_pkg::*;;
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [BYTE_W-1:0]  out_byte;
    logic [BYTE_W-1:0]  header_byte;
    logic [TOPIC_W-1:0] topic_length;
    logic [LEN_W-1:0]   payload_length;
    logic [LEN_W-1:0]   packet_length;
    logic               last;

    modport source (output valid, output kind, output out_byte, output header_byte,
                    output topic_length, output payload_length, output packet_length,
                    output last, input ready);
    modport sink   (input valid, input kind, input out_byte, input header_byte,
                    input topic_length, input payload_length, input packet_length,
                    input last, output ready);
endinterface

`default_nettype wire

/* rtl/mpsp_core.sv */
// ----------------------------------------------------------------------------
// mpsp_core
// input register, packet state update and result formation (up to two a byte)
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "mqtt_publish_stream_parser_macros.svh"

module mpsp_core import mpsp_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    mpsp_in_if.sink     i_in,
    input  wire logic   i_room,
    output logic [1:0]  o_push_cnt,
    output t_result     o_res0,
    output t_result     o_res1
);

    // input register
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_data;
    logic              r_restart;

    // packet state
    t_phase             r_phase,  n_phase;
    logic [BYTE_W-1:0]  r_header, n_header;
    logic [LEN_W-1:0]   r_acc,    n_acc;
    logic [1:0]         r_vcnt,   n_vcnt;
    logic [LEN_W-1:0]   r_rem,    n_rem;
    logic [TOPIC_W-1:0] r_tsize,  n_tsize;
    logic [TOPIC_W-1:0] r_trem,   n_trem;
    logic               r_err,    n_err;

    logic               w_proc;
    logic               w_active;
    t_phase             w_phase;
    logic [LEN_W-1:0]   w_acc_shift;
    logic [LEN_W-1:0]   w_acc_new;
    logic               w_overlong;
    logic               w_nonpub;
    logic [LEN_W-1:0]   w_rem_dec;
    logic [TOPIC_W-1:0] w_topic_new;
    logic               w_topic_fail;
    logic [TOPIC_W-1:0] w_trem_dec;

    logic               w_have_a;
    t_kind              w_kind_a;
    logic               w_have_d;

    assign w_proc     = r_in_valid && i_room;
    assign i_in.ready = !r_in_valid || i_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_data    <= i_in.data_byte;
            r_restart <= i_in.restart;
        end
    end

    // restart puts the byte in the header phase before it is handled
    assign w_active = r_restart || !r_err;
    assign w_phase  = r_restart ? PH_HEADER : r_phase;

    // base-128 digit placed by its position in the length field
    always_comb begin
        unique case (r_vcnt)
            2'd0:    w_acc_shift = LEN_W'(r_data[6:0]);
            2'd1:    w_acc_shift = LEN_W'(r_data[6:0]) << 7;
            2'd2:    w_acc_shift = LEN_W'(r_data[6:0]) << 14;
            default: w_acc_shift = LEN_W'(r_data[6:0]) << 21;
        endcase
    end

    assign w_acc_new    = r_acc | w_acc_shift;
    assign w_overlong   = ({1'b0, r_vcnt} + 3'd1) >= 3'(MAX_LENGTH_BYTES);
    assign w_nonpub     = r_header[7:4] != PUBLISH_TYPE;
    assign w_rem_dec    = r_rem - LEN_W'(1);
    assign w_topic_new  = {r_tsize[TOPIC_W-1:BYTE_W], r_data};
    assign w_topic_fail = LEN_W'(w_topic_new) > w_rem_dec;
    assign w_trem_dec   = r_trem - TOPIC_W'(1);

    // next state
    always_comb begin
        n_phase  = r_phase;
        n_header = r_header;
        n_acc    = r_acc;
        n_vcnt   = r_vcnt;
        n_rem    = r_rem;
        n_tsize  = r_tsize;
        n_trem   = r_trem;
        n_err    = r_err;
        if (w_proc) begin
            if (r_restart) begin
                n_err   = 1'b0;
                n_phase = PH_HEADER;
            end
            if (w_active) begin
                unique case (w_phase)
                    PH_LENGTH: begin
                        n_acc = w_acc_new;
                        if (r_data[7]) begin
                            if (w_overlong) begin
                                n_err   = 1'b1;
                                n_phase = PH_HEADER;
                            end else begin
                                n_vcnt = r_vcnt + 2'd1;
                            end
                        end else begin
                            n_rem = w_acc_new;
                            if (w_nonpub) begin
                                n_phase = (w_acc_new == '0) ? PH_HEADER : PH_SKIP;
                            end else if (w_acc_new < LEN_W'(2)) begin
                                n_err   = 1'b1;
                                n_phase = PH_HEADER;
                            end else begin
                                n_phase = PH_TOPIC_HI;
                            end
                        end
                    end
                    PH_TOPIC_HI: begin
                        n_tsize = {r_data, 8'h00};
                        n_rem   = w_rem_dec;
                        n_phase = PH_TOPIC_LO;
                    end
                    PH_TOPIC_LO: begin
                        n_tsize = w_topic_new;
                        n_rem   = w_rem_dec;
                        if (w_topic_fail) begin
                            n_err   = 1'b1;
                            n_phase = PH_HEADER;
                        end else begin
                            n_trem = w_topic_new;
                            if (w_topic_new != '0) begin
                                n_phase = PH_TOPIC;
                            end else if (w_rem_dec == '0) begin
                                n_phase = PH_HEADER;
                            end else begin
                                n_phase = PH_PAYLOAD;
                            end
                        end
                    end
                    PH_TOPIC: begin
                        n_trem = w_trem_dec;
                        n_rem  = w_rem_dec;
                        if (w_trem_dec == '0) begin
                            n_phase = (w_rem_dec == '0) ? PH_HEADER : PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD, PH_SKIP: begin
                        n_rem = w_rem_dec;
                        if (w_rem_dec == '0) begin
                            n_phase = PH_HEADER;
                        end
                    end
                    default: begin
                        // header phase, unused codes land here too
                        n_header = r_data;
                        n_acc    = '0;
                        n_vcnt   = '0;
                        n_rem    = '0;
                        n_tsize  = '0;
                        n_trem   = '0;
                        n_phase  = PH_LENGTH;
                    end
                endcase
            end
        end
    end

    // results of this byte
    always_comb begin
        w_have_a = 1'b0;
        w_kind_a = K_ERROR;
        w_have_d = 1'b0;
        if (w_proc && w_active) begin
            unique case (w_phase)
                PH_LENGTH: begin
                    if (r_data[7]) begin
                        w_have_a = w_overlong;
                        w_kind_a = K_ERROR;
                    end else if (w_nonpub) begin
                        w_have_a = (w_acc_new == '0);
                        w_kind_a = K_SKIPPED;
                    end else begin
                        w_have_a = (w_acc_new < LEN_W'(2));
                        w_kind_a = K_ERROR;
                    end
                end
                PH_TOPIC_LO: begin
                    w_have_a = w_topic_fail;
                    w_kind_a = K_ERROR;
                    w_have_d = !w_topic_fail && (w_topic_new == '0) && (w_rem_dec == '0);
                end
                PH_TOPIC: begin
                    w_have_a = 1'b1;
                    w_kind_a = K_TOPIC;
                    w_have_d = (w_trem_dec == '0) && (w_rem_dec == '0);
                end
                PH_PAYLOAD: begin
                    w_have_a = 1'b1;
                    w_kind_a = K_PAYLOAD;
                    w_have_d = (w_rem_dec == '0);
                end
                PH_SKIP: begin
                    w_have_a = (w_rem_dec == '0);
                    w_kind_a = K_SKIPPED;
                end
                default: begin
                    w_have_a = 1'b0;
                end
            endcase
        end
    end

    assign o_push_cnt = {1'b0, w_have_a} + {1'b0, w_have_d};
    assign o_res0 = w_have_a
        ? mk_result(w_kind_a, r_data, n_header, n_tsize, n_acc, !w_have_d)
        : mk_result(K_DONE, '0, n_header, n_tsize, n_acc, 1'b1);
    assign o_res1 = mk_result(K_DONE, '0, n_header, n_tsize, n_acc, 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_header <= '0;
            r_acc    <= '0;
            r_vcnt   <= '0;
            r_rem    <= '0;
            r_tsize  <= '0;
            r_trem   <= '0;
            r_err    <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_header <= n_header;
            r_acc    <= n_acc;
            r_vcnt   <= n_vcnt;
            r_rem    <= n_rem;
            r_tsize  <= n_tsize;
            r_trem   <= n_trem;
            r_err    <= n_err;
        end
    end

    `MPSP_CHECK_IMPL(a_sticky_silent, r_err && r_in_valid && !r_restart, o_push_cnt == 2'd0, "result while error is sticky")
    `MPSP_CHECK_IMPL(a_pair_ends_done, o_push_cnt == 2'd2, o_res1.kind == K_DONE && o_res0.kind != K_ERROR, "bad result pair")
    `MPSP_CHECK_NEXT(a_error_sets_sticky, o_push_cnt != 2'd0 && o_res0.kind == K_ERROR, r_err && r_phase == PH_HEADER, "error not held")

endmodule

`default_nettype wire

/* rtl/mpsp_rq.sv */
// ----------------------------------------------------------------------------
// mpsp_rq
// result queue taking up to two results a cycle and handing out one
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "mqtt_publish_stream_parser_macros.svh"

module mpsp_rq import mpsp_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [1:0] i_push_cnt,
    input  wire t_result    i_res0,
    input  wire t_result    i_res1,
    output logic            o_room,
    mpsp_out_if.source      o_out
);

    t_result               r_entry [RQ_DEPTH];
    logic [RQ_PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [RQ_PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [RQ_CNT_W-1:0]   r_count,  n_count;
    logic                  w_pop;
    logic [RQ_PTR_W-1:0]   w_wr_ptr1;
    t_result               w_head;

    assign w_pop     = o_out.valid && o_out.ready;
    assign w_wr_ptr1 = r_wr_ptr + RQ_PTR_W'(1);
    // room for a full pair of results, whatever leaves this cycle
    assign o_room    = r_count <= RQ_CNT_W'(RQ_DEPTH - 2);

    always_comb begin
        n_wr_ptr = r_wr_ptr + RQ_PTR_W'(i_push_cnt);
        n_rd_ptr = r_rd_ptr + RQ_PTR_W'(w_pop);
        n_count  = r_count + RQ_CNT_W'(i_push_cnt) - RQ_CNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_entry[r_wr_ptr] <= i_res0;
        end
        if (i_push_cnt == 2'd2) begin
            r_entry[w_wr_ptr1] <= i_res1;
        end
    end

    assign w_head               = r_entry[r_rd_ptr];
    assign o_out.valid          = r_count != '0;
    assign o_out.kind           = w_head.kind;
    assign o_out.out_byte       = w_head.out_byte;
    assign o_out.header_byte    = w_head.header_byte;
    assign o_out.topic_length   = w_head.topic_length;
    assign o_out.payload_length = w_head.payload_length;
    assign o_out.packet_length  = w_head.packet_length;
    assign o_out.last           = w_head.last;

    `MPSP_CHECK(a_count_bound, r_count <= RQ_CNT_W'(RQ_DEPTH), "result queue overfilled")
    `MPSP_CHECK_IMPL(a_push_needs_room, i_push_cnt != 2'd0, o_room && i_push_cnt != 2'd3, "push without room")

endmodule

`default_nettype wire

/* rtl/mqtt_publish_stream_parser.sv */
// An accepted byte is registered in the input register, its results enter the result queue, and the
// first one shows at the output; the byte waits in the input register while the queue lacks room.
// Throughput: one byte per cycle while the queue has room for two results; a topic or payload byte ending
// the packet gives two, which leave at one per cycle while the output is ready, via the four-entry queue.
// Reset: synchronous, active low; parser returns to the header phase, error and queue clear.
// ----------------------------------------------------------------------------
// mqtt_publish_stream_parser
// mqtt byte stream parser reporting publish topic and payload bytes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mqtt_publish_stream_parser import mpsp_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mpsp_in_if.sink    i_in,
    mpsp_out_if.source o_out
);

    logic       w_room;
    logic [1:0] w_push_cnt;
    t_result    w_res0;
    t_result    w_res1;

    mpsp_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_room     (w_room),
        .o_push_cnt (w_push_cnt),
        .o_res0     (w_res0),
        .o_res1     (w_res1)
    );

    mpsp_rq u_rq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (w_push_cnt),
        .i_res0     (w_res0),
        .i_res1     (w_res1),
        .o_room     (w_room),
        .o_out      (o_out)
    );

endmodule

`default_nettype wire

/* verif/mpsp_result_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpsp_result_checker
// watches the byte and result channels of the publish parser, tracks the
// parse of every accepted byte and compares each result field by field
// ----------------------------------------------------------------------------

module mpsp_result_checker import mpsp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    mpsp_in_if   i_bytes,
    mpsp_out_if  i_results,
    output int   o_mismatches,
    output int   o_outstanding
);

    t_phase             ph;
    logic [BYTE_W-1:0]  hdr;
    logic [LEN_W-1:0]   acc;
    logic [1:0]         vcnt;
    logic [LEN_W-1:0]   remain;
    logic [TOPIC_W-1:0] tsize;
    logic [TOPIC_W-1:0] trem;
    logic               err;

    t_result parser_results[$];
    t_result step_out[$];
    int      mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    task automatic report_mismatch(input string what, input logic [LEN_W-1:0] got,
                                   input logic [LEN_W-1:0] want);
        $display("%0t mismatch on %s: got 0x%0h, wanted 0x%0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // result fields taken from the packet being parsed
    function automatic t_result parsed_entry(input t_kind k, input logic [BYTE_W-1:0] b);
        t_result r;
        logic    sized;
        sized            = (k == K_TOPIC) || (k == K_PAYLOAD) || (k == K_DONE);
        r.kind           = k;
        r.out_byte       = ((k == K_TOPIC) || (k == K_PAYLOAD)) ? b : '0;
        r.header_byte    = hdr;
        r.topic_length   = sized ? tsize : '0;
        r.payload_length = sized ? (acc - LEN_W'(2) - {12'd0, tsize}) : '0;
        r.packet_length  = acc;
        r.last           = 1'b0;
        return r;
    endfunction

    function automatic void raise_error();
        err = 1'b1;
        ph  = PH_HEADER;
        step_out.push_back(parsed_entry(K_ERROR, 8'h00));
    endfunction

    task automatic parse_byte(input logic [BYTE_W-1:0] b, input logic rs);
        t_result tail;
        step_out.delete();
        if (rs) begin
            err = 1'b0;
            ph  = PH_HEADER;
        end
        if (!err) begin
            case (ph)
                PH_LENGTH: begin
                    acc = acc | (LEN_W'(b[6:0]) << (7 * vcnt));
                    if (b[7]) begin
                        if (int'(vcnt) + 1 >= MAX_LENGTH_BYTES) raise_error();
                        else vcnt = vcnt + 2'd1;
                    end else begin
                        remain = acc;
                        if (hdr[7:4] != PUBLISH_TYPE) begin
                            if (remain == '0) begin
                                step_out.push_back(parsed_entry(K_SKIPPED, 8'h00));
                                ph = PH_HEADER;
                            end else begin
                                ph = PH_SKIP;
                            end
                        end else if (remain < LEN_W'(2)) begin
                            raise_error();
                        end else begin
                            ph = PH_TOPIC_HI;
                        end
                    end
                end
                PH_TOPIC_HI: begin
                    tsize  = {b, 8'h00};
                    remain = remain - LEN_W'(1);
                    ph     = PH_TOPIC_LO;
                end
                PH_TOPIC_LO: begin
                    tsize  = tsize | {8'h00, b};
                    remain = remain - LEN_W'(1);
                    if ({12'd0, tsize} > remain) begin
                        raise_error();
                    end else begin
                        trem = tsize;
                        if (tsize != '0) begin
                            ph = PH_TOPIC;
                        end else if (remain == '0) begin
                            step_out.push_back(parsed_entry(K_DONE, 8'h00));
                            ph = PH_HEADER;
                        end else begin
                            ph = PH_PAYLOAD;
                        end
                    end
                end
                PH_TOPIC: begin
                    step_out.push_back(parsed_entry(K_TOPIC, b));
                    trem   = trem - TOPIC_W'(1);
                    remain = remain - LEN_W'(1);
                    if (trem == '0) begin
                        if (remain == '0) begin
                            step_out.push_back(parsed_entry(K_DONE, 8'h00));
                            ph = PH_HEADER;
                        end else begin
                            ph = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    step_out.push_back(parsed_entry(K_PAYLOAD, b));
                    remain = remain - LEN_W'(1);
                    if (remain == '0) begin
                        step_out.push_back(parsed_entry(K_DONE, 8'h00));
                        ph = PH_HEADER;
                    end
                end
                PH_SKIP: begin
                    remain = remain - LEN_W'(1);
                    if (remain == '0) begin
                        step_out.push_back(parsed_entry(K_SKIPPED, 8'h00));
                        ph = PH_HEADER;
                    end
                end
                default: begin
                    hdr    = b;
                    acc    = '0;
                    vcnt   = '0;
                    remain = '0;
                    tsize  = '0;
                    trem   = '0;
                    ph     = PH_LENGTH;
                end
            endcase
        end
        if (step_out.size() > 0) begin
            tail      = step_out.pop_back();
            tail.last = 1'b1;
            step_out.push_back(tail);
        end
        foreach (step_out[i]) parser_results.push_back(step_out[i]);
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            ph     = PH_HEADER;
            hdr    = '0;
            acc    = '0;
            vcnt   = '0;
            remain = '0;
            tsize  = '0;
            trem   = '0;
            err    = 1'b0;
            parser_results.delete();
        end else begin
            if (i_results.valid && i_results.ready) begin
                if (parser_results.size() == 0) begin
                    report_mismatch("result with nothing pending", LEN_W'(i_results.kind), '0);
                end else begin
                    want = parser_results.pop_front();
                    if (i_results.kind !== want.kind)
                        report_mismatch("kind", LEN_W'(i_results.kind), LEN_W'(want.kind));
                    if (i_results.out_byte !== want.out_byte)
                        report_mismatch("out_byte", LEN_W'(i_results.out_byte),
                                        LEN_W'(want.out_byte));
                    if (i_results.header_byte !== want.header_byte)
                        report_mismatch("header_byte", LEN_W'(i_results.header_byte),
                                        LEN_W'(want.header_byte));
                    if (i_results.topic_length !== want.topic_length)
                        report_mismatch("topic_length", LEN_W'(i_results.topic_length),
                                        LEN_W'(want.topic_length));
                    if (i_results.payload_length !== want.payload_length)
                        report_mismatch("payload_length", i_results.payload_length,
                                        want.payload_length);
                    if (i_results.packet_length !== want.packet_length)
                        report_mismatch("packet_length", i_results.packet_length,
                                        want.packet_length);
                    if (i_results.last !== want.last)
                        report_mismatch("last", LEN_W'(i_results.last), LEN_W'(want.last));
                end
            end
            if (i_bytes.valid && i_bytes.ready)
                parse_byte(i_bytes.data_byte, i_bytes.restart);
        end
        o_outstanding <= parser_results.size();
    end

endmodule

/* verif/tb_mqtt_publish_stream_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mqtt_publish_stream_parser
// drives directed and random mqtt byte streams into the publish parser under
// several idle and stall mixes; a side checker predicts and compares results
// ----------------------------------------------------------------------------

module tb_mqtt_publish_stream_parser;
    import mpsp_pkg::*;

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   stall_pct;
    int   bytes_sent;
    bit   need_restart;
    int   mismatches;
    int   outstanding;

    mpsp_in_if  in_if ();
    mpsp_out_if out_if ();

    mqtt_publish_stream_parser DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source)
    );

    mpsp_result_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_bytes       (in_if),
        .i_results     (out_if),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk) out_if.ready <= ($urandom_range(99) >= stall_pct);

    initial begin
        #2_000_000;
        $display("FAIL mqtt_publish_stream_parser");
        $finish;
    end

    task automatic push_byte(input logic [7:0] b, input logic rs);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid     <= 1'b1;
        in_if.data_byte <= b;
        in_if.restart   <= rs;
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
        bytes_sent++;
    endtask

    // restart is forced after anything that may leave the parser in error
    function automatic logic header_restart();
        logic rs;
        rs           = need_restart || ($urandom_range(7) == 0);
        need_restart = 1'b0;
        return rs;
    endfunction

    // base-128 length, stretched to nbytes with zero groups
    task automatic send_length(input int len, input int nbytes);
        logic [6:0] grp;
        for (int i = 0; i < nbytes; i++) begin
            grp = 7'((len >> (7 * i)) & 'h7f);
            push_byte({(i < nbytes - 1), grp}, 1'b0);
        end
    endtask

    task automatic send_random_bytes(input int n);
        for (int i = 0; i < n; i++) push_byte(8'($urandom), 1'b0);
    endtask

    task automatic send_publish(input int tlen, input int plen);
        push_byte({PUBLISH_TYPE, 4'($urandom)}, header_restart());
        send_length(2 + tlen + plen, $urandom_range(1, MAX_LENGTH_BYTES));
        push_byte(8'(tlen >> 8), 1'b0);
        push_byte(8'(tlen), 1'b0);
        send_random_bytes(tlen + plen);
    endtask

    task automatic send_other(input int len);
        logic [3:0] ptype;
        do ptype = 4'($urandom); while (ptype == PUBLISH_TYPE);
        push_byte({ptype, 4'($urandom)}, header_restart());
        send_length(len, $urandom_range(1, MAX_LENGTH_BYTES));
        send_random_bytes(len);
    endtask

    task automatic send_broken();
        int         r;
        int         nb;
        logic [3:0] ptype;
        case ($urandom_range(3))
            0: begin
                // length field that never ends
                push_byte(8'($urandom), header_restart());
                for (int i = 0; i < MAX_LENGTH_BYTES; i++)
                    push_byte({1'b1, 7'($urandom)}, 1'b0);
                send_random_bytes($urandom_range(0, 2));
            end
            1: begin
                // publish too short for its topic length bytes
                push_byte({PUBLISH_TYPE, 4'($urandom)}, header_restart());
                send_length($urandom_range(0, 1), $urandom_range(1, MAX_LENGTH_BYTES));
                send_random_bytes($urandom_range(0, 2));
            end
            2: begin
                // topic longer than the packet
                r = $urandom_range(2, 10);
                push_byte({PUBLISH_TYPE, 4'($urandom)}, header_restart());
                send_length(r, 1);
                nb = $urandom_range(r - 1, 16'hffff);
                push_byte(8'(nb >> 8), 1'b0);
                push_byte(8'(nb), 1'b0);
                send_random_bytes($urandom_range(0, 2));
            end
            default: begin
                // huge length, cut short by a restart
                ptype = ($urandom_range(1) == 0) ? PUBLISH_TYPE : 4'($urandom);
                push_byte({ptype, 4'($urandom)}, header_restart());
                nb = $urandom_range(2, MAX_LENGTH_BYTES);
                for (int i = 0; i < nb; i++)
                    push_byte({(i < nb - 1), 7'($urandom)}, 1'b0);
                send_random_bytes($urandom_range(1, 6));
            end
        endcase
        need_restart = 1'b1;
    endtask

    initial begin
        int pick;
        int tlen;
        int plen;
        int nb;
        rst_n           = 1'b0;
        in_if.valid     = 1'b0;
        in_if.data_byte = 8'h00;
        in_if.restart   = 1'b0;
        send_idle_pct   = 0;
        stall_pct       = 0;
        bytes_sent      = 0;
        need_restart    = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty topic and payload, done on the topic length byte
        push_byte(8'h30, 1'b0);
        push_byte(8'h02, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        // one topic byte, then done on the same byte
        push_byte(8'h3f, 1'b0);
        push_byte(8'h03, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(8'hff, 1'b0);
        // empty non-publish packet
        push_byte(8'hc0, 1'b0);
        push_byte(8'h00, 1'b0);
        // short publish, then a byte swallowed by the error
        push_byte(8'h30, 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(8'hff, 1'b0);
        // overlong length after a restart
        push_byte(8'he0, 1'b1);
        push_byte(8'hff, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'hff, 1'b0);
        // largest topic length in a tiny packet
        push_byte(8'h32, 1'b1);
        push_byte(8'h04, 1'b0);
        push_byte(8'hff, 1'b0);
        push_byte(8'hff, 1'b0);
        // zero-length publish
        push_byte(8'h30, 1'b1);
        push_byte(8'h00, 1'b0);
        need_restart = 1'b1;

        for (int phase = 0; phase < 4; phase++) begin
            // let everything in flight drain before changing the mix
            in_if.valid <= 1'b0;
            @(posedge clk);
            while (outstanding != 0) @(posedge clk);
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 80; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 80; end
                default: begin send_idle_pct = 21; stall_pct = 21; end
            endcase
            while (bytes_sent < 25 + 125 * (phase + 1)) begin
                pick = $urandom_range(99);
                if (pick < 60) begin
                    tlen = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 5);
                    plen = ($urandom_range(5) == 0) ? 0 : $urandom_range(1, 12);
                    send_publish(tlen, plen);
                end else if (pick < 75) begin
                    send_other($urandom_range(0, 6));
                end else if (pick < 95) begin
                    send_broken();
                end else begin
                    nb = $urandom_range(1, 6);
                    for (int i = 0; i < nb; i++)
                        push_byte(8'($urandom), ($urandom_range(9) == 0));
                    need_restart = 1'b1;
                end
            end
        end

        in_if.valid <= 1'b0;
        stall_pct = 0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("PASS mqtt_publish_stream_parser");
        end else begin
            $display("FAIL mqtt_publish_stream_parser");
        end
        $finish;
    end

endmodule
